// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, held off while reset is low
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_AT(label, !(cond), msg)

`endif

// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned RES_W    = $clog2(MAX_RES + 1);
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned MLEN_W   = 3;

  localparam logic [7:0] SEP_LIMIT = 8'd32;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [1:0] VEC_ARGS  = 2'd3;
  localparam logic [1:0] VAR_ARGS  = 2'd1;
  localparam logic [MLEN_W-1:0] MLEN_MAX = '1;
  localparam logic [KW_COUNT-1:0] PREFIX_ALL = '1;

  localparam int unsigned KW_VEC  = 0;
  localparam int unsigned KW_ROT  = 1;
  localparam int unsigned KW_FN   = 2;
  localparam int unsigned KW_NAME = 3;
  localparam int unsigned KW_VAR  = 4;

  // keyword text, character 0 in the low byte of each row
  localparam logic [KW_COUNT-1:0][4:0][7:0] KW_TEXT = {
    {8'h00, ":", "r", "a", "v"},
    {":", "e", "m", "a", "n"},
    {8'h00, 8'h00, ":", "n", "f"},
    {8'h00, ":", "t", "o", "r"},
    {8'h00, ":", "c", "e", "v"}
  };
  localparam logic [KW_COUNT-1:0][MLEN_W-1:0] KW_LEN = {
    3'd4, 3'd5, 3'd3, 3'd4, 3'd4
  };

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_EOT   = 2'd1,
    KIND_EOM   = 2'd2
  } kind_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [RES_W-1:0]              cnt;
    kind_t [MAX_RES-1:0]           kind;
    logic [MAX_RES-1:0][7:0]       data;
  } bundle_t;

  function automatic logic [KW_COUNT-1:0] kw_match(input logic [KW_COUNT-1:0] prefix,
                                                   input logic [MLEN_W-1:0] mlen,
                                                   input logic [7:0] b);
    logic [KW_COUNT-1:0] res;
    res = prefix;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (mlen >= KW_LEN[k]) begin
        res[k] = 1'b0;
      end else if (KW_TEXT[k][mlen] != b) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic kw_hit(input logic [KW_COUNT-1:0] prefix,
                                  input logic [MLEN_W-1:0] mlen,
                                  input int unsigned k);
    return prefix[k] && (mlen == KW_LEN[k]);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    case (b)
      "n":     return 8'd10;
      "t":     return 8'd9;
      "r":     return 8'd13;
      "0":     return 8'd0;
      default: return b;
    endcase
  endfunction

endpackage

// ===== rtl/core/clt_front.sv =====
`include "assert_macros.svh"

module clt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             push,
  output clt_pkg::bundle_t push_bundle
);

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_ESCAPE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    JOIN_NONE = 2'd0,
    JOIN_VEC  = 2'd1,
    JOIN_VAR  = 2'd2
  } join_t;

  mode_t                          mode_r, mode_nxt;
  logic                           qsingle_r, qsingle_nxt;
  logic [clt_pkg::KW_COUNT-1:0]   prefix_r, prefix_nxt;
  logic [clt_pkg::MLEN_W-1:0]     mlen_r, mlen_nxt;
  join_t                          join_r, join_nxt;
  logic [1:0]                     jleft_r, jleft_nxt;
  logic                           colon_r, colon_nxt;

  logic                           accept;
  clt_pkg::op_t                   op;
  logic [clt_pkg::RES_W-1:0]      n;
  logic                           comma_en, tb_en, end_en;
  logic [7:0]                     tb_val;
  logic [7:0]                     quote_ch;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign op        = clt_pkg::op_t'(in_tuser);
  assign quote_ch  = qsingle_r ? clt_pkg::CH_SQUOTE : clt_pkg::CH_DQUOTE;

  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    prefix_nxt  = prefix_r;
    mlen_nxt    = mlen_r;
    join_nxt    = join_r;
    jleft_nxt   = jleft_r;
    colon_nxt   = colon_r;
    comma_en    = 1'b0;
    tb_en       = 1'b0;
    end_en      = 1'b0;
    tb_val      = in_tdata;
    n           = '0;
    push_bundle = '0;

    // classify the beat
    if (op == clt_pkg::OP_END) begin
      tb_en  = (mode_r == MODE_ESCAPE);
      tb_val = clt_pkg::CH_BSLASH;
      end_en = (mode_r != MODE_BETWEEN);
    end else begin
      case (mode_r)
        MODE_BETWEEN: begin
          if (in_tdata > clt_pkg::SEP_LIMIT) begin
            comma_en   = (join_r == JOIN_VEC) && !colon_r;
            prefix_nxt = clt_pkg::PREFIX_ALL;
            mlen_nxt   = '0;
            if (in_tdata == clt_pkg::CH_DQUOTE || in_tdata == clt_pkg::CH_SQUOTE) begin
              mode_nxt    = MODE_QUOTED;
              qsingle_nxt = (in_tdata == clt_pkg::CH_SQUOTE);
            end else begin
              mode_nxt = MODE_PLAIN;
              tb_en    = 1'b1;
            end
          end
        end
        MODE_PLAIN: begin
          if (in_tdata <= clt_pkg::SEP_LIMIT) begin
            end_en = 1'b1;
          end else begin
            tb_en = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (in_tdata == quote_ch) begin
            end_en = 1'b1;
          end else if (in_tdata == clt_pkg::CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            tb_en = 1'b1;
          end
        end
        default: begin
          tb_en    = 1'b1;
          tb_val   = clt_pkg::unescape(in_tdata);
          mode_nxt = MODE_QUOTED;
        end
      endcase
    end

    if (comma_en) begin
      push_bundle.kind[n] = clt_pkg::KIND_TOKEN;
      push_bundle.data[n] = clt_pkg::CH_COMMA;
      n         = n + 1'b1;
      colon_nxt = 1'b0;
    end

    if (tb_en) begin
      prefix_nxt = clt_pkg::kw_match(prefix_nxt, mlen_nxt, tb_val);
      if (mlen_nxt != clt_pkg::MLEN_MAX) begin
        mlen_nxt = mlen_nxt + 1'b1;
      end
      push_bundle.kind[n] = clt_pkg::KIND_TOKEN;
      push_bundle.data[n] = tb_val;
      n         = n + 1'b1;
      colon_nxt = (tb_val == clt_pkg::CH_COLON);
    end

    if (end_en) begin
      if (join_r != JOIN_NONE) begin
        jleft_nxt = jleft_r - 1'b1;
        if (jleft_nxt == 2'd0) begin
          join_nxt = JOIN_NONE;
          push_bundle.kind[n] = clt_pkg::KIND_EOT;
          n = n + 1'b1;
        end
      end else if (clt_pkg::kw_hit(prefix_nxt, mlen_nxt, clt_pkg::KW_VEC) ||
                   clt_pkg::kw_hit(prefix_nxt, mlen_nxt, clt_pkg::KW_ROT)) begin
        join_nxt  = JOIN_VEC;
        jleft_nxt = clt_pkg::VEC_ARGS;
      end else if (clt_pkg::kw_hit(prefix_nxt, mlen_nxt, clt_pkg::KW_FN) ||
                   clt_pkg::kw_hit(prefix_nxt, mlen_nxt, clt_pkg::KW_NAME) ||
                   clt_pkg::kw_hit(prefix_nxt, mlen_nxt, clt_pkg::KW_VAR)) begin
        join_nxt  = JOIN_VAR;
        jleft_nxt = clt_pkg::VAR_ARGS;
      end else begin
        push_bundle.kind[n] = clt_pkg::KIND_EOT;
        n = n + 1'b1;
      end
      mode_nxt   = MODE_BETWEEN;
      prefix_nxt = clt_pkg::PREFIX_ALL;
      mlen_nxt   = '0;
    end

    if (op == clt_pkg::OP_END) begin
      // a join still open at end of message closes short
      if (join_nxt != JOIN_NONE) begin
        push_bundle.kind[n] = clt_pkg::KIND_EOT;
        n = n + 1'b1;
      end
      push_bundle.kind[n] = clt_pkg::KIND_EOM;
      n = n + 1'b1;
      mode_nxt    = MODE_BETWEEN;
      qsingle_nxt = 1'b0;
      prefix_nxt  = clt_pkg::PREFIX_ALL;
      mlen_nxt    = '0;
      join_nxt    = JOIN_NONE;
      jleft_nxt   = '0;
      colon_nxt   = 1'b0;
    end

    push_bundle.cnt = n;
  end

  assign push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      qsingle_r <= 1'b0;
      prefix_r  <= clt_pkg::PREFIX_ALL;
      mlen_r    <= '0;
      join_r    <= JOIN_NONE;
      jleft_r   <= '0;
      colon_r   <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      prefix_r  <= prefix_nxt;
      mlen_r    <= mlen_nxt;
      join_r    <= join_nxt;
      jleft_r   <= jleft_nxt;
      colon_r   <= colon_nxt;
    end
  end

  `ASSERT_AT(a_eom_clears, (accept && op == clt_pkg::OP_END) |=> (mode_r == MODE_BETWEEN && join_r == JOIN_NONE && mlen_r == '0), "end of message left scan state behind")

endmodule

// ===== rtl/core/clt_queue.sv =====
`include "assert_macros.svh"

module clt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  clt_pkg::bundle_t wr_bundle,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output clt_pkg::bundle_t head
);

  clt_pkg::bundle_t              mem [clt_pkg::QDEPTH];
  logic [clt_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [clt_pkg::QCNT_W-1:0]    count_r;

  assign full       = (count_r == clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == clt_pkg::QPTR_W'(clt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == clt_pkg::QPTR_W'(clt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "bundle pushed into a full queue")
  `ASSERT_NEVER(a_no_underflow, pop && !head_valid, "bundle popped from an empty queue")

endmodule

// ===== rtl/core/clt_back.sv =====
`include "assert_macros.svh"

module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  clt_pkg::bundle_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic [clt_pkg::RES_W-1:0] sub_r;
  logic                      out_valid_r;
  clt_pkg::kind_t            out_kind_r;
  logic [7:0]                out_data_r;
  logic                      out_last_r;
  logic                      load;
  logic                      sel_last;
  logic [1:0]                sel_idx;

  // output slot refills as the current beat leaves
  assign load     = head_valid && (!out_valid_r || out_tready);
  assign sel_idx  = sub_r[1:0];
  assign sel_last = (sub_r == head.cnt - 1'b1);
  assign pop      = load && sel_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= sel_last ? '0 : sub_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= head.kind[sel_idx];
      out_data_r <= head.data[sel_idx];
      out_last_r <= sel_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // results of one input beat leave without gaps
  `ASSERT_AT(a_run_contiguous, (out_valid_r && out_tready && !out_last_r) |=> out_valid_r, "gap inside a run of results")
  `ASSERT_AT(a_sub_has_head, (sub_r != '0) |-> head_valid, "partial bundle without a queue head")

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// a result passes through a queue entry and then the output register before out_tvalid
// throughput: one input beat per cycle while the queue has room; the output stage sends
//   one result beat per cycle while out_tready holds; a beat's k results go out in order
// a four-entry queue of per-beat result bundles lets bursts of multi-result beats pass
// reset: synchronous, active low; clears scan state, queue and output stage
module command_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // run_last
);

  logic             q_full;
  logic             push;
  clt_pkg::bundle_t push_bundle;
  logic             pop;
  logic             head_valid;
  clt_pkg::bundle_t head;

  clt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  clt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_bundle  (push_bundle),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  clt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
